[rtl/hst_pkg.sv]
package hst_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // field widths
  localparam int KEY_W  = 8;
  localparam int TIME_W = 32;
  localparam int MISS_W = 8;
  localparam int DEB_W  = 8;
  localparam int PER_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CFGA_W = 1;

  // command codes
  localparam logic [1:0] CMD_REGISTER  = 2'd0;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;
  localparam logic [1:0] CMD_UPDATE    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOREG = 2'd2;

  // configuration register indexes
  localparam logic [CFGA_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFGA_W-1:0] CFG_BLINK    = 1'b1;

  // configuration reset values
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd3;
  localparam logic [PER_W-1:0] BLINK_RST    = 16'd250;

  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  // table write operations
  typedef enum logic [2:0] {
    WR_NONE,
    WR_NEW,
    WR_TMO,
    WR_BEAT,
    WR_HEALTH
  } tbl_op_t;

  typedef struct packed {
    tbl_op_t             op;
    logic [SLOT_W-1:0]   idx;
    logic [KEY_W-1:0]    dev_type;
    logic [KEY_W-1:0]    dev_index;
    logic [TIME_W-1:0]   timeout;
    logic [TIME_W-1:0]   stamp;
    logic [MISS_W-1:0]   misses;
    logic                online;
  } tbl_wr_t;

  // one slot as seen through the read port
  typedef struct packed {
    logic                used;
    logic                online;
    logic [MISS_W-1:0]   misses;
    logic [KEY_W-1:0]    dev_type;
    logic [KEY_W-1:0]    dev_index;
    logic [TIME_W-1:0]   timeout;
    logic [TIME_W-1:0]   last_beat;
  } slot_view_t;

  // shared time comparator result
  typedef struct packed {
    logic gt;
    logic ge;
  } cmp_res_t;

endpackage

[rtl/heartbeat_supervisor_table_top.sv]
// Heartbeat supervisor table: holds up to MAX_ENTRIES devices keyed by
// (type, index). cmd in in_tuser picks register, heartbeat, query or periodic
// update. Register, heartbeat and query return one beat with out_tlast set;
// an update returns one beat per used slot in slot order (or a single empty
// beat when the table is empty), with the all-up flag on the last beat, and
// every beat carries the LED and buzzer levels after the command. A table slot
// is read one per cycle through a single read port (the listing pass waits
// while the result register holds a beat not yet taken), and the timeout and
// blink checks share one 32-bit wrapping compare unit. in_tready is high only
// while the block is idle; the result register lets the next command be
// accepted while the last result still waits.
module heartbeat_supervisor_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: dev_type[7:0], dev_index[15:8], hb_timeout[47:16], now_ms[79:48]
  input  logic [79:0]                       in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: entry_type[7:0], entry_index[15:8], entry_online[16],
  //            all_up[17], led_red[18], led_green[19], buzzer[20], zero[23:21]
  output logic [23:0]                       out_tdata,
  // out_tuser: status[1:0], entry_valid[2]
  output logic [2:0]                        out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [hst_pkg::CFGA_W-1:0]        cfg_index,
  input  logic [hst_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_ACT   = 5'b00100,
    S_UPD   = 5'b01000,
    S_ALARM = 5'b10000
  } state_t;

  localparam int SW = hst_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(hst_pkg::MAX_ENTRIES - 1);

  // list state is folded into the update path via a flag
  state_t                        state_r, state_nxt;
  logic                          listing_r, listing_nxt;
  logic [SW-1:0]                 cnt_r, cnt_nxt;
  logic [1:0]                    cmd_r, cmd_nxt;
  logic [hst_pkg::KEY_W-1:0]     key_type_r, key_type_nxt;
  logic [hst_pkg::KEY_W-1:0]     key_index_r, key_index_nxt;
  logic [hst_pkg::TIME_W-1:0]    tmo_r, tmo_nxt;
  logic [hst_pkg::TIME_W-1:0]    now_r, now_nxt;
  logic                          found_r, found_nxt;
  logic [SW-1:0]                 hit_r, hit_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [SW-1:0]                 free_r, free_nxt;
  logic                          all_r, all_nxt;

  // alarm state
  logic                          prev_all_r, prev_all_nxt;
  logic                          blink_on_r, blink_on_nxt;
  logic [hst_pkg::TIME_W-1:0]    last_blink_r, last_blink_nxt;
  logic                          red_r, red_nxt;
  logic                          green_r, green_nxt;
  logic                          buzz_r, buzz_nxt;

  // configuration
  logic [hst_pkg::DEB_W-1:0]     debounce_r;
  logic [hst_pkg::PER_W-1:0]     period_r;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    o_status_r, o_status_nxt;
  logic                          o_ev_r, o_ev_nxt;
  logic [hst_pkg::KEY_W-1:0]     o_type_r, o_type_nxt;
  logic [hst_pkg::KEY_W-1:0]     o_index_r, o_index_nxt;
  logic                          o_online_r, o_online_nxt;
  logic                          o_last_r, o_last_nxt;
  logic                          o_all_r, o_all_nxt;
  logic                          o_red_r, o_red_nxt;
  logic                          o_green_r, o_green_nxt;
  logic                          o_buzz_r, o_buzz_nxt;

  logic                          can_put;
  logic                          put;
  logic [SW-1:0]                 rd_idx;
  hst_pkg::tbl_wr_t              tbl_wr;
  hst_pkg::slot_view_t           view;
  logic [hst_pkg::MAX_ENTRIES-1:0] used_vec;
  logic [hst_pkg::TIME_W-1:0]    cmp_stamp;
  logic [hst_pkg::TIME_W-1:0]    cmp_limit;
  hst_pkg::cmp_res_t             cmp_res;
  logic                          key_hit;
  logic                          later_used;
  logic [hst_pkg::MISS_W-1:0]    miss_new;
  logic                          online_new;

  // slot store
  assign rd_idx = (state_r == S_ACT) ? (found_r ? hit_r : free_r) : cnt_r;

  hst_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .wr       (tbl_wr),
    .view     (view),
    .used_vec (used_vec)
  );

  // shared compare: slot timeout during the health pass, blink period in the alarm step
  assign cmp_stamp = (state_r == S_ALARM) ? last_blink_r : view.last_beat;
  assign cmp_limit = (state_r == S_ALARM) ? {{(hst_pkg::TIME_W - hst_pkg::PER_W){1'b0}}, period_r}
                                          : view.timeout;

  hst_cmp u_cmp (
    .now   (now_r),
    .stamp (cmp_stamp),
    .limit (cmp_limit),
    .res   (cmp_res)
  );

  assign key_hit    = view.used && (view.dev_type == key_type_r) &&
                      (view.dev_index == key_index_r);
  assign later_used = |(used_vec >> ({1'b0, cnt_r} + (SW + 1)'(1)));

  // miss counting and debounce for the slot under the scan
  always_comb begin
    if (cmp_res.gt) begin
      miss_new = (view.misses == hst_pkg::MISS_MAX) ? view.misses
                                                    : view.misses + hst_pkg::MISS_W'(1);
    end else begin
      miss_new = '0;
    end
    online_new = (miss_new >= debounce_r) ? 1'b0 : view.online;
  end

  assign can_put   = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    listing_nxt    = listing_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    key_type_nxt   = key_type_r;
    key_index_nxt  = key_index_r;
    tmo_nxt        = tmo_r;
    now_nxt        = now_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    all_nxt        = all_r;
    prev_all_nxt   = prev_all_r;
    blink_on_nxt   = blink_on_r;
    last_blink_nxt = last_blink_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    buzz_nxt       = buzz_r;

    put          = 1'b0;
    o_status_nxt = o_status_r;
    o_ev_nxt     = o_ev_r;
    o_type_nxt   = o_type_r;
    o_index_nxt  = o_index_r;
    o_online_nxt = o_online_r;
    o_last_nxt   = o_last_r;
    o_all_nxt    = o_all_r;

    tbl_wr           = '0;
    tbl_wr.op        = hst_pkg::WR_NONE;
    tbl_wr.idx       = rd_idx;
    tbl_wr.dev_type  = key_type_r;
    tbl_wr.dev_index = key_index_r;
    tbl_wr.timeout   = tmo_r;
    tbl_wr.stamp     = now_r;
    tbl_wr.misses    = miss_new;
    tbl_wr.online    = online_new;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_tuser;
          key_type_nxt   = in_tdata[7:0];
          key_index_nxt  = in_tdata[15:8];
          tmo_nxt        = in_tdata[47:16];
          now_nxt        = in_tdata[79:48];
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          all_nxt        = 1'b1;
          listing_nxt    = 1'b0;
          state_nxt      = (in_tuser == hst_pkg::CMD_UPDATE) ? S_UPD : S_LOOK;
        end
      end

      // key search and first free slot, one slot a cycle
      S_LOOK: begin
        if (key_hit && !found_r) begin
          found_nxt = 1'b1;
          hit_nxt   = cnt_r;
        end
        if (!view.used && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_nxt       = cnt_r;
        end
        if (cnt_r == LAST_SLOT) begin
          state_nxt = S_ACT;
        end else begin
          cnt_nxt = cnt_r + SW'(1);
        end
      end

      // apply the command and post its single result
      S_ACT: begin
        if (can_put) begin
          put          = 1'b1;
          o_ev_nxt     = 1'b0;
          o_type_nxt   = key_type_r;
          o_index_nxt  = key_index_r;
          o_last_nxt   = 1'b1;
          o_all_nxt    = 1'b0;
          o_status_nxt = hst_pkg::ST_OK;
          o_online_nxt = 1'b0;
          case (cmd_r)
            hst_pkg::CMD_REGISTER: begin
              if (found_r) begin
                tbl_wr.op    = hst_pkg::WR_TMO;
                o_online_nxt = view.online;
              end else if (free_found_r) begin
                tbl_wr.op    = hst_pkg::WR_NEW;
                o_online_nxt = 1'b1;
              end else begin
                o_status_nxt = hst_pkg::ST_FULL;
              end
            end
            hst_pkg::CMD_HEARTBEAT: begin
              if (found_r) begin
                tbl_wr.op    = hst_pkg::WR_BEAT;
                o_online_nxt = 1'b1;
              end else begin
                o_status_nxt = hst_pkg::ST_NOREG;
              end
            end
            default: begin
              if (found_r) begin
                o_online_nxt = view.online;
              end else begin
                o_status_nxt = hst_pkg::ST_NOREG;
              end
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      // health pass, then the listing pass over the same counter
      S_UPD: begin
        if (!listing_r) begin
          if (view.used) begin
            tbl_wr.op = hst_pkg::WR_HEALTH;
            if (!online_new) begin
              all_nxt = 1'b0;
            end
          end
          if (cnt_r == LAST_SLOT) begin
            state_nxt = S_ALARM;
          end else begin
            cnt_nxt = cnt_r + SW'(1);
          end
        end else if (used_vec == '0) begin
          if (can_put) begin
            put          = 1'b1;
            o_status_nxt = hst_pkg::ST_OK;
            o_ev_nxt     = 1'b0;
            o_type_nxt   = '0;
            o_index_nxt  = '0;
            o_online_nxt = 1'b0;
            o_last_nxt   = 1'b1;
            o_all_nxt    = all_r;
            state_nxt    = S_IDLE;
          end
        end else if (view.used) begin
          if (can_put) begin
            put          = 1'b1;
            o_status_nxt = hst_pkg::ST_OK;
            o_ev_nxt     = 1'b1;
            o_type_nxt   = view.dev_type;
            o_index_nxt  = view.dev_index;
            o_online_nxt = view.online;
            o_last_nxt   = !later_used;
            o_all_nxt    = !later_used && all_r;
            if (!later_used) begin
              state_nxt = S_IDLE;
            end else begin
              cnt_nxt = cnt_r + SW'(1);
            end
          end
        end else begin
          cnt_nxt = cnt_r + SW'(1);
        end
      end

      // alarm drive and blink timing
      S_ALARM: begin
        if (all_r) begin
          if (!prev_all_r) begin
            red_nxt      = 1'b0;
            green_nxt    = 1'b1;
            buzz_nxt     = 1'b0;
            blink_on_nxt = 1'b0;
          end
        end else if (prev_all_r) begin
          red_nxt        = 1'b1;
          green_nxt      = 1'b0;
          buzz_nxt       = 1'b1;
          blink_on_nxt   = 1'b1;
          last_blink_nxt = now_r;
        end else if (cmp_res.ge) begin
          last_blink_nxt = now_r;
          blink_on_nxt   = !blink_on_r;
          red_nxt        = !blink_on_r;
          green_nxt      = 1'b0;
          buzz_nxt       = !blink_on_r;
        end
        prev_all_nxt = all_r;
        cnt_nxt      = '0;
        listing_nxt  = 1'b1;
        state_nxt    = S_UPD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = put ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    o_red_nxt     = put ? red_nxt   : o_red_r;
    o_green_nxt   = put ? green_nxt : o_green_r;
    o_buzz_nxt    = put ? buzz_nxt  : o_buzz_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      listing_r    <= 1'b0;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      all_r        <= 1'b1;
      prev_all_r   <= 1'b1;
      blink_on_r   <= 1'b0;
      last_blink_r <= '0;
      red_r        <= 1'b0;
      green_r      <= 1'b0;
      buzz_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      listing_r    <= listing_nxt;
      cnt_r        <= cnt_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      all_r        <= all_nxt;
      prev_all_r   <= prev_all_nxt;
      blink_on_r   <= blink_on_nxt;
      last_blink_r <= last_blink_nxt;
      red_r        <= red_nxt;
      green_r      <= green_nxt;
      buzz_r       <= buzz_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_type_r  <= key_type_nxt;
    key_index_r <= key_index_nxt;
    tmo_r       <= tmo_nxt;
    now_r       <= now_nxt;
    hit_r       <= hit_nxt;
    free_r      <= free_nxt;
    o_status_r  <= o_status_nxt;
    o_ev_r      <= o_ev_nxt;
    o_type_r    <= o_type_nxt;
    o_index_r   <= o_index_nxt;
    o_online_r  <= o_online_nxt;
    o_last_r    <= o_last_nxt;
    o_all_r     <= o_all_nxt;
    o_red_r     <= o_red_nxt;
    o_green_r   <= o_green_nxt;
    o_buzz_r    <= o_buzz_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= hst_pkg::DEBOUNCE_RST;
      period_r   <= hst_pkg::BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hst_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data[hst_pkg::DEB_W-1:0];
        hst_pkg::CFG_BLINK:    period_r   <= cfg_data[hst_pkg::PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = {o_ev_r, o_status_r};
  assign out_tdata  = {3'b000, o_buzz_r, o_green_r, o_red_r, o_all_r, o_online_r,
                       o_index_r, o_type_r};

endmodule

[rtl/hst_table.sv]
module hst_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [hst_pkg::SLOT_W-1:0]          rd_idx,
  input  hst_pkg::tbl_wr_t                    wr,
  output hst_pkg::slot_view_t                 view,
  output logic [hst_pkg::MAX_ENTRIES-1:0]     used_vec
);

  logic [hst_pkg::MAX_ENTRIES-1:0] used_r;
  logic [hst_pkg::MAX_ENTRIES-1:0] online_r;
  logic [hst_pkg::MISS_W-1:0]      misses_r    [hst_pkg::MAX_ENTRIES];
  logic [hst_pkg::KEY_W-1:0]       type_r      [hst_pkg::MAX_ENTRIES];
  logic [hst_pkg::KEY_W-1:0]       index_r     [hst_pkg::MAX_ENTRIES];
  logic [hst_pkg::TIME_W-1:0]      timeout_r   [hst_pkg::MAX_ENTRIES];
  logic [hst_pkg::TIME_W-1:0]      last_beat_r [hst_pkg::MAX_ENTRIES];

  // status flags and miss counters, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      online_r <= '0;
      for (int i = 0; i < hst_pkg::MAX_ENTRIES; i++) begin
        misses_r[i] <= '0;
      end
    end else begin
      case (wr.op)
        hst_pkg::WR_NEW: begin
          used_r[wr.idx]   <= 1'b1;
          online_r[wr.idx] <= 1'b1;
          misses_r[wr.idx] <= '0;
        end
        hst_pkg::WR_BEAT: begin
          online_r[wr.idx] <= 1'b1;
        end
        hst_pkg::WR_HEALTH: begin
          online_r[wr.idx] <= wr.online;
          misses_r[wr.idx] <= wr.misses;
        end
        default: begin
        end
      endcase
    end
  end

  // key, timeout and stamp payload, valid only while the slot is used
  always_ff @(posedge clk) begin
    case (wr.op)
      hst_pkg::WR_NEW: begin
        type_r[wr.idx]      <= wr.dev_type;
        index_r[wr.idx]     <= wr.dev_index;
        timeout_r[wr.idx]   <= wr.timeout;
        last_beat_r[wr.idx] <= wr.stamp;
      end
      hst_pkg::WR_TMO: begin
        timeout_r[wr.idx] <= wr.timeout;
      end
      hst_pkg::WR_BEAT: begin
        last_beat_r[wr.idx] <= wr.stamp;
      end
      default: begin
      end
    endcase
  end

  // single read port
  always_comb begin
    view.used      = used_r[rd_idx];
    view.online    = online_r[rd_idx];
    view.misses    = misses_r[rd_idx];
    view.dev_type  = type_r[rd_idx];
    view.dev_index = index_r[rd_idx];
    view.timeout   = timeout_r[rd_idx];
    view.last_beat = last_beat_r[rd_idx];
  end

  assign used_vec = used_r;

endmodule

[rtl/hst_cmp.sv]
module hst_cmp (
  input  logic [hst_pkg::TIME_W-1:0] now,
  input  logic [hst_pkg::TIME_W-1:0] stamp,
  input  logic [hst_pkg::TIME_W-1:0] limit,
  output hst_pkg::cmp_res_t          res
);

  logic [hst_pkg::TIME_W-1:0] elapsed;

  // wrapping elapsed time against a limit
  assign elapsed = now - stamp;
  assign res.gt  = elapsed > limit;
  assign res.ge  = elapsed >= limit;

endmodule

[rtl/hst_checker.sv]
module hst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) &&
                                  $stable(out_tlast))
    else $error("result beat changed while stalled");

  // one command at a time: accepting a beat drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready held after accepting a command");

  // listed entries always report ok status
  a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == 2'd0)
    else $error("listed entry with error status");

  // anything that is not a listed entry is a single-beat result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast)
    else $error("non-list result without last");

  // the all-up flag only shows on the final beat
  a_all_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[17])
    else $error("all-up flag set before the last beat");

endmodule

bind heartbeat_supervisor_table_top hst_checker u_hst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
